/* hdl/pafk_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the planar arm kinematics unit.
`default_nettype none

package pafk_pkg;

  localparam int DEF_TRIG_FRACTION_BITS = 15;
  localparam int DEF_OUT_FRACTION_BITS  = 4;

  localparam int NUM_LINKS   = 3;
  localparam int CELL_STAGES = 4;
  localparam int ANGLE_W     = 10;
  localparam int TURN_W      = 9;
  localparam int IDX_W       = 7;
  localparam int LEN_W       = 12;
  localparam int BASE_W      = 13;
  localparam int OUT_W       = 19;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam int QUARTER_DEG       = 90;
  localparam int HALF_TURN_DEG     = 180;
  localparam int THREE_QUARTER_DEG = 270;
  localparam int FULL_TURN_DEG     = 360;

  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  localparam int SERIES_BITS  = 28;
  localparam int SERIES_W     = SERIES_BITS + 1;
  localparam int SERIES_TERMS = 10;
  localparam logic [63:0] PI_SERIES = 64'h3243_F6A9;
  localparam logic [9:0] SERIES_DIV [1:SERIES_TERMS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210, 10'd272, 10'd342, 10'd420
  };

  typedef enum logic [2:0] {
    REG_BASE_X       = 3'd0,
    REG_BASE_Y       = 3'd1,
    REG_LINK1_LENGTH = 3'd2,
    REG_LINK2_LENGTH = 3'd3,
    REG_LINK3_LENGTH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [BASE_W-1:0]         base_x;
    logic signed [BASE_W-1:0]         base_y;
    logic [NUM_LINKS-1:0][LEN_W-1:0]  length;
  } pafk_cfg_t;

  typedef struct packed {
    logic                              valid;
    logic [NUM_LINKS-1:0][ANGLE_W-1:0] joint;
    logic [TURN_W-1:0]                 angle;
  } pafk_word_t;

  typedef logic [SERIES_W-1:0] series_rom_t [0:QUARTER_DEG];

  // Sine of k degrees from a truncated Taylor series with 28 fraction bits.
  function automatic logic [SERIES_W-1:0] quarter_series(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * PI_SERIES + 64'd90) / 64'd180;
    x2   = (x * x) >> SERIES_BITS;
    term = x;
    sum  = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = (term * x2) >> SERIES_BITS;
      term = term / 64'(SERIES_DIV[n]);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return SERIES_W'(sum);
  endfunction

  function automatic series_rom_t build_series_rom();
    series_rom_t rom;
    for (int k = 0; k <= QUARTER_DEG; k++) begin
      rom[k] = quarter_series(k);
    end
    return rom;
  endfunction

  localparam series_rom_t SERIES_ROM = build_series_rom();

endpackage

`default_nettype wire

/* hdl/pafk_regs.sv */
// Register file behind the APB-style configuration port.
`default_nettype none

module pafk_regs
  import pafk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output pafk_cfg_t              cfg
);

  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_BASE_X:       cfg.base_x    <= pwdata[BASE_W-1:0];
        REG_BASE_Y:       cfg.base_y    <= pwdata[BASE_W-1:0];
        REG_LINK1_LENGTH: cfg.length[0] <= pwdata[LEN_W-1:0];
        REG_LINK2_LENGTH: cfg.length[1] <= pwdata[LEN_W-1:0];
        REG_LINK3_LENGTH: cfg.length[2] <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_X:       prdata = DATA_W'(cfg.base_x);
      REG_BASE_Y:       prdata = DATA_W'(cfg.base_y);
      REG_LINK1_LENGTH: prdata = DATA_W'(cfg.length[0]);
      REG_LINK2_LENGTH: prdata = DATA_W'(cfg.length[1]);
      REG_LINK3_LENGTH: prdata = DATA_W'(cfg.length[2]);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/pafk_link_cell.sv */
// One link cell: cumulative angle, sine and cosine lookup, products, and accumulation.
`default_nettype none

module pafk_link_cell
  import pafk_pkg::*;
#(
  parameter int LINK               = 0,
  parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic [LEN_W-1:0]     length,
  input  wire pafk_word_t           in_word,
  input  wire logic signed [TRIG_FRACTION_BITS+15:0] in_acc_x,
  input  wire logic signed [TRIG_FRACTION_BITS+15:0] in_acc_y,
  output pafk_word_t                out_word,
  output logic signed [TRIG_FRACTION_BITS+15:0]      out_acc_x,
  output logic signed [TRIG_FRACTION_BITS+15:0]      out_acc_y
);

  localparam int ACC_W     = TRIG_FRACTION_BITS + 16;
  localparam int TRIG_W    = TRIG_FRACTION_BITS + 2;
  localparam int PROD_W    = LEN_W + 1 + TRIG_W;
  localparam int SUM_W     = ANGLE_W + 1;
  localparam int ROM_SHIFT = SERIES_BITS - TRIG_FRACTION_BITS;
  localparam int ROM_EXT   = SERIES_W + 1;

  localparam logic signed [SUM_W-1:0] TURN      = SUM_W'(FULL_TURN_DEG);
  localparam logic signed [SUM_W-1:0] TWO_TURNS = SUM_W'(2 * FULL_TURN_DEG);
  localparam logic [ROM_EXT-1:0]      ROM_HALF  = ROM_EXT'(2 ** (ROM_SHIFT - 1));
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(2 ** TRIG_FRACTION_BITS);
  localparam logic [TURN_W-1:0] Q1 = TURN_W'(QUARTER_DEG);
  localparam logic [TURN_W-1:0] Q2 = TURN_W'(HALF_TURN_DEG);
  localparam logic [TURN_W-1:0] Q3 = TURN_W'(THREE_QUARTER_DEG);
  localparam logic [TURN_W-1:0] Q4 = TURN_W'(FULL_TURN_DEG);

  logic [TRIG_W-2:0] sine_rom [0:QUARTER_DEG];

  for (genvar k = 0; k <= QUARTER_DEG; k++) begin : g_rom
    assign sine_rom[k] = (TRIG_W-1)'((ROM_EXT'(SERIES_ROM[k]) + ROM_HALF) >> ROM_SHIFT);
  end

  // Stage A: cumulative angle reduced into one turn.
  logic signed [SUM_W-1:0] angle_sum;
  logic signed [SUM_W-1:0] angle_red;
  pafk_word_t              a_word;
  pafk_word_t              a_word_next;
  logic signed [ACC_W-1:0] a_acc_x;
  logic signed [ACC_W-1:0] a_acc_y;

  assign angle_sum = $signed({2'b00, in_word.angle}) + SUM_W'($signed(in_word.joint[LINK]));

  always_comb begin
    priority if (angle_sum < -TURN) begin
      angle_red = angle_sum + TWO_TURNS;
    end else if (angle_sum < 0) begin
      angle_red = angle_sum + TURN;
    end else if (angle_sum >= TWO_TURNS) begin
      angle_red = angle_sum - TWO_TURNS;
    end else if (angle_sum >= TURN) begin
      angle_red = angle_sum - TURN;
    end else begin
      angle_red = angle_sum;
    end
    a_word_next       = in_word;
    a_word_next.angle = angle_red[TURN_W-1:0];
  end

  // Stage B: quadrant folding and table lookup.
  logic [TURN_W-1:0]        a_ang;
  logic [IDX_W-1:0]         sin_k;
  logic [IDX_W-1:0]         cos_k;
  logic                     sin_neg;
  logic                     cos_neg;
  logic [TRIG_W-2:0]        sin_mag;
  logic [TRIG_W-2:0]        cos_mag;
  pafk_word_t               b_word;
  logic signed [ACC_W-1:0]  b_acc_x;
  logic signed [ACC_W-1:0]  b_acc_y;
  logic signed [TRIG_W-1:0] b_sin;
  logic signed [TRIG_W-1:0] b_cos;

  assign a_ang = a_word.angle;

  always_comb begin
    priority if (a_ang <= Q1) begin
      sin_k   = IDX_W'(a_ang);
      sin_neg = 1'b0;
      cos_k   = IDX_W'(Q1 - a_ang);
      cos_neg = 1'b0;
    end else if (a_ang <= Q2) begin
      sin_k   = IDX_W'(Q2 - a_ang);
      sin_neg = 1'b0;
      cos_k   = IDX_W'(a_ang - Q1);
      cos_neg = 1'b1;
    end else if (a_ang <= Q3) begin
      sin_k   = IDX_W'(a_ang - Q2);
      sin_neg = 1'b1;
      cos_k   = IDX_W'(Q3 - a_ang);
      cos_neg = 1'b1;
    end else begin
      sin_k   = IDX_W'(Q4 - a_ang);
      sin_neg = 1'b1;
      cos_k   = IDX_W'(a_ang - Q3);
      cos_neg = 1'b0;
    end
  end

  assign sin_mag = sine_rom[sin_k];
  assign cos_mag = sine_rom[cos_k];

  // Stage C: products; stage D: accumulation.
  pafk_word_t               c_word;
  logic signed [ACC_W-1:0]  c_acc_x;
  logic signed [ACC_W-1:0]  c_acc_y;
  logic signed [PROD_W-1:0] c_prod_x;
  logic signed [PROD_W-1:0] c_prod_y;
  logic signed [LEN_W:0]    len_s;

  assign len_s = $signed({1'b0, length});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_word.valid   <= 1'b0;
      b_word.valid   <= 1'b0;
      c_word.valid   <= 1'b0;
      out_word.valid <= 1'b0;
    end else if (adv) begin
      a_word    <= a_word_next;
      a_acc_x   <= in_acc_x;
      a_acc_y   <= in_acc_y;
      b_word    <= a_word;
      b_acc_x   <= a_acc_x;
      b_acc_y   <= a_acc_y;
      b_sin     <= sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      b_cos     <= cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      c_word    <= b_word;
      c_acc_x   <= b_acc_x;
      c_acc_y   <= b_acc_y;
      c_prod_x  <= len_s * b_sin;
      c_prod_y  <= len_s * b_cos;
      out_word  <= c_word;
      out_acc_x <= c_acc_x + ACC_W'(c_prod_x);
      out_acc_y <= c_acc_y + ACC_W'(c_prod_y);
    end
  end

  a_angle_in_turn: assert property (@(posedge clk) disable iff (rst)
    a_word.valid |-> (a_word.angle < Q4))
    else $error("cumulative angle left the range of one turn");

  b_sine_bounded: assert property (@(posedge clk) disable iff (rst)
    b_word.valid |-> (b_sin <= TRIG_ONE) && (b_sin >= -TRIG_ONE))
    else $error("sine value beyond unity");

  b_cosine_bounded: assert property (@(posedge clk) disable iff (rst)
    b_word.valid |-> (b_cos <= TRIG_ONE) && (b_cos >= -TRIG_ONE))
    else $error("cosine value beyond unity");

  d_holds_when_stopped: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out_word.valid))
    else $error("cell output moved while the pipeline was stopped");

endmodule

`default_nettype wire

/* hdl/pafk_out_stage.sv */
// Output stage: rounding to the output fraction, saturation and the result register.
`default_nettype none

module pafk_out_stage
  import pafk_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS,
  parameter int OUT_FRACTION_BITS  = DEF_OUT_FRACTION_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [TRIG_FRACTION_BITS+15:0] acc_x,
  input  wire logic signed [TRIG_FRACTION_BITS+15:0] acc_y,
  input  wire logic                 tip_stall,
  output logic                      adv,
  output logic                      tip_valid,
  output logic signed [OUT_W-1:0]   tip_x,
  output logic signed [OUT_W-1:0]   tip_y
);

  localparam int ACC_W = TRIG_FRACTION_BITS + 16;
  localparam int SUM_W = ACC_W + 1;
  localparam int SHIFT = TRIG_FRACTION_BITS - OUT_FRACTION_BITS;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(2 ** (SHIFT - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

  function automatic logic [OUT_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] rnd;
    biased = SUM_W'(v) + HALF;
    rnd    = biased >>> SHIFT;
    if (rnd > SAT_HI) begin
      rnd = SAT_HI;
    end else if (rnd < SAT_LO) begin
      rnd = SAT_LO;
    end
    return rnd[OUT_W-1:0];
  endfunction

  assign adv = !tip_valid || !tip_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tip_valid <= 1'b0;
    end else if (adv) begin
      tip_valid <= in_valid;
      tip_x     <= round_sat(acc_x);
      tip_y     <= round_sat(acc_y);
    end
  end

endmodule

`default_nettype wire

/* hdl/planar_arm_forward_kinematics_unit.sv */
// Top level of the planar three-link arm end-point unit.
// An accepted angle word passes four stages in each of the three link cells and one in
// the output stage before its tip word appears, and waits while the tip word is stalled.
// Throughput: one word per cycle; the whole cell chain advances together and halts only
// when a finished tip word is held by tip_stall.
// Reset clears all valid flags and sets the base offsets and link lengths to zero.
`default_nettype none

module planar_arm_forward_kinematics_unit
  import pafk_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS,
  parameter int OUT_FRACTION_BITS  = DEF_OUT_FRACTION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic      [DATA_W-1:0]         prdata,
  output logic                           pready,
  input  wire logic                      angle_valid,
  output logic                           angle_stall,
  input  wire logic signed [ANGLE_W-1:0] joint1_angle,
  input  wire logic signed [ANGLE_W-1:0] joint2_angle,
  input  wire logic signed [ANGLE_W-1:0] joint3_angle,
  output logic                           tip_valid,
  input  wire logic                      tip_stall,
  output logic signed [OUT_W-1:0]        tip_x,
  output logic signed [OUT_W-1:0]        tip_y
);

  localparam int ACC_W = TRIG_FRACTION_BITS + 16;

  pafk_cfg_t               cfg;
  logic                    adv;
  pafk_word_t              link_word  [0:NUM_LINKS];
  logic signed [ACC_W-1:0] link_acc_x [0:NUM_LINKS];
  logic signed [ACC_W-1:0] link_acc_y [0:NUM_LINKS];

  assign pready      = 1'b1;
  assign angle_stall = !adv;

  pafk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_comb begin
    link_word[0].valid    = angle_valid;
    link_word[0].joint[0] = joint1_angle;
    link_word[0].joint[1] = joint2_angle;
    link_word[0].joint[2] = joint3_angle;
    link_word[0].angle    = '0;
  end

  assign link_acc_x[0] = ACC_W'(cfg.base_x) <<< TRIG_FRACTION_BITS;
  assign link_acc_y[0] = ACC_W'(cfg.base_y) <<< TRIG_FRACTION_BITS;

  for (genvar i = 0; i < NUM_LINKS; i++) begin : g_cell
    pafk_link_cell #(
      .LINK               (i),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .length    (cfg.length[i]),
      .in_word   (link_word[i]),
      .in_acc_x  (link_acc_x[i]),
      .in_acc_y  (link_acc_y[i]),
      .out_word  (link_word[i+1]),
      .out_acc_x (link_acc_x[i+1]),
      .out_acc_y (link_acc_y[i+1])
    );
  end

  pafk_out_stage #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS),
    .OUT_FRACTION_BITS  (OUT_FRACTION_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_word[NUM_LINKS].valid),
    .acc_x     (link_acc_x[NUM_LINKS]),
    .acc_y     (link_acc_y[NUM_LINKS]),
    .tip_stall (tip_stall),
    .adv       (adv),
    .tip_valid (tip_valid),
    .tip_x     (tip_x),
    .tip_y     (tip_y)
  );

endmodule

`default_nettype wire
